// ===== rtl/sbsl_pkg.sv =====
// ---------------------------------------------------------------------------
// Source block symbol locator package
// Field widths, register indexes, sequencer states and divider structs.
// ---------------------------------------------------------------------------
package sbsl_pkg;

   // Field widths
   localparam int LEN_W   = 48;
   localparam int ESZ_W   = 16;
   localparam int BMAX_W  = 32;
   localparam int SBN_W   = 16;
   localparam int ESI_W   = 16;
   localparam int CSR_W   = 48;
   localparam int CSR_IDX_W = 2;

   // Divider width and step counter width
   localparam int DIV_W   = 48;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFER_BYTES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_BYTES      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BLOCK_SYMBOLS = 2'd2;

   // Register reset values
   localparam logic [LEN_W-1:0]  TRANSFER_BYTES_RST    = 48'd0;
   localparam logic [ESZ_W-1:0]  SYMBOL_BYTES_RST      = 16'd1024;
   localparam logic [BMAX_W-1:0] MAX_BLOCK_SYMBOLS_RST = 32'd64;

   // Partition sequencer states
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_DIV_T,
      SEQ_START_N,
      SEQ_DIV_N,
      SEQ_START_B,
      SEQ_DIV_B
   } seq_state_type;

   // Divider request and response
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/sbsl_req_if.sv =====
// ---------------------------------------------------------------------------
// Locator request channel
// Valid/ready channel carrying one block number and symbol index.
// ---------------------------------------------------------------------------
interface sbsl_req_if import sbsl_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [SBN_W-1:0] block_number;
   logic [ESI_W-1:0] symbol_index;

   modport source (output valid, block_number, symbol_index, input ready);
   modport sink   (input valid, block_number, symbol_index, output ready);
endinterface

// ===== rtl/sbsl_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Locator response channel
// Valid/ready channel carrying the location of one symbol.
// ---------------------------------------------------------------------------
interface sbsl_rsp_if import sbsl_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              in_range;
   logic [BMAX_W-1:0] block_symbols;
   logic [ESZ_W-1:0]  sym_len;
   logic [LEN_W-1:0]  byte_offset;
   logic [LEN_W-1:0]  block_count;

   modport source (output valid, in_range, block_symbols, sym_len, byte_offset,
                   block_count, input ready);
   modport sink   (input valid, in_range, block_symbols, sym_len, byte_offset,
                   block_count, output ready);
endinterface

// ===== rtl/sbsl_divider.sv =====
// ---------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle.
// ---------------------------------------------------------------------------
module sbsl_divider import sbsl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       trial;

   // Shift in the next dividend bit and try the subtraction
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};

   // Load on start, step while busy
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dsr_in   = div_req.divisor;
         count_in = DIV_CNT_W'(DIV_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
         end else begin
            rem_in = shifted[DIV_W-1:0];
         end
         quo_in   = {quo_ff[DIV_W-2:0], ~trial[DIV_W]};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== rtl/source_block_symbol_locator_unit.sv =====
// ---------------------------------------------------------------------------
// Source block symbol locator
// RFC 5052 source block partitioning and symbol lookup, one lookup a cycle when not stalled.
// ---------------------------------------------------------------------------
// Usage:
//   csr_we/csr_index/csr_wdata set the object length, symbol size and maximum
//   block length. Each write starts a recompute of the partition (symbol
//   count, block count, large and small block lengths, large block count)
//   as three divisions in turn on one shared 48-bit divider (skipped when
//   a register is zero), while req.ready stays low.
//   req carries (block_number, symbol_index) transactions; rsp returns
//   in_range, block_symbols, sym_len, byte_offset and block_count.
//   Each accepted transaction passes through the four pipeline stages
//   (select and block multiply, symbol add, byte multiply, tail clamp)
//   before rsp.valid rises. Throughput is one transaction per cycle while
//   rsp.ready is high and no recompute is running.
//   Every stage holds its own valid bit and loads whenever it is empty or
//   its successor moves, so a stalled rsp only backs up as far as needed
//   and bubbles are squeezed out; nothing is lost or repeated.
//   Reset restores the register defaults, which describe an empty object,
//   so the partition is ready at once and every pair reports out of range.
// ---------------------------------------------------------------------------
module source_block_symbol_locator_unit import sbsl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   sbsl_req_if.sink             req,
   sbsl_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Configuration registers
   logic [LEN_W-1:0]  len_ff;
   logic [ESZ_W-1:0]  esz_ff;
   logic [BMAX_W-1:0] bmax_ff;

   // Partition values
   logic [LEN_W-1:0]  total_ff;
   logic [LEN_W-1:0]  nblk_ff;
   logic [LEN_W-1:0]  nlarge_ff;
   logic [BMAX_W-1:0] small_ff;
   logic [BMAX_W-1:0] large_ff;

   seq_state_type seq_state_ff, seq_state_in;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   logic          degenerate;
   logic          part_busy;
   logic [DIV_W-1:0] quo_up;

   // Pipeline stage registers
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic              s1_blk_ok_ff;
   logic [BMAX_W-1:0] s1_bsyms_ff, s2_bsyms_ff, s3_bsyms_ff, s4_bsyms_ff;
   logic [LEN_W-1:0]  s1_prod_ff;
   logic [SBN_W-1:0]  s1_min_ff;
   logic [ESI_W-1:0]  s1_esi_ff;
   logic              s2_ok_ff, s3_ok_ff, s4_ok_ff;
   logic [LEN_W-1:0]  s2_sym_ff;
   logic [LEN_W-1:0]  s3_offset_ff, s4_offset_ff;
   logic [ESZ_W-1:0]  s4_slen_ff;

   logic              ld1, ld2, ld3, ld4;
   logic              s1_blk_ok_in, s1_large_in;
   logic [BMAX_W-1:0] s1_bsyms_in;
   logic [LEN_W-1:0]  s1_prod_in;
   logic [SBN_W-1:0]  s1_min_in;
   logic              s2_ok_in;
   logic [LEN_W-1:0]  s2_sym_in;
   logic [LEN_W-1:0]  s3_offset_in;
   logic [LEN_W-1:0]  s4_rest;
   logic [ESZ_W-1:0]  s4_slen_in;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= TRANSFER_BYTES_RST;
         esz_ff  <= SYMBOL_BYTES_RST;
         bmax_ff <= MAX_BLOCK_SYMBOLS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRANSFER_BYTES:    len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_SYMBOL_BYTES:      esz_ff  <= csr_wdata[ESZ_W-1:0];
            CSR_MAX_BLOCK_SYMBOLS: bmax_ff <= csr_wdata[BMAX_W-1:0];
            default: ;
         endcase
      end
   end

   // Partition sequencer: next state
   assign degenerate = (len_ff == '0) || (esz_ff == '0) || (bmax_ff == '0);

   always_comb begin
      seq_state_in = seq_state_ff;
      case (seq_state_ff)
         SEQ_IDLE:    seq_state_in = SEQ_IDLE;
         SEQ_START:   seq_state_in = degenerate ? SEQ_IDLE : SEQ_DIV_T;
         SEQ_DIV_T:   if (div_rsp.done) seq_state_in = SEQ_START_N;
         SEQ_START_N: seq_state_in = SEQ_DIV_N;
         SEQ_DIV_N:   if (div_rsp.done) seq_state_in = SEQ_START_B;
         SEQ_START_B: seq_state_in = SEQ_DIV_B;
         SEQ_DIV_B:   if (div_rsp.done) seq_state_in = SEQ_IDLE;
         default:     seq_state_in = SEQ_IDLE;
      endcase
      if (csr_we) begin
         seq_state_in = SEQ_START;
      end
   end

   // Partition sequencer: divider operands
   always_comb begin
      div_req = '0;
      case (seq_state_ff)
         SEQ_START: begin
            div_req.start    = !degenerate;
            div_req.dividend = len_ff;
            div_req.divisor  = DIV_W'(esz_ff);
         end
         SEQ_START_N: begin
            div_req.start    = 1'b1;
            div_req.dividend = total_ff;
            div_req.divisor  = DIV_W'(bmax_ff);
         end
         SEQ_START_B: begin
            div_req.start    = 1'b1;
            div_req.dividend = total_ff;
            div_req.divisor  = nblk_ff;
         end
         default: div_req = '0;
      endcase
   end

   assign part_busy = (seq_state_ff != SEQ_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= SEQ_IDLE;
      end else begin
         seq_state_ff <= seq_state_in;
      end
   end

   sbsl_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Round the quotient up when a remainder is left
   assign quo_up = div_rsp.quotient + DIV_W'(div_rsp.remainder != '0);

   // Capture partition values as each division finishes
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         nblk_ff   <= '0;
         nlarge_ff <= '0;
         small_ff  <= '0;
         large_ff  <= '0;
      end else begin
         case (seq_state_ff)
            SEQ_START: begin
               if (degenerate) begin
                  total_ff  <= '0;
                  nblk_ff   <= '0;
                  nlarge_ff <= '0;
                  small_ff  <= '0;
                  large_ff  <= '0;
               end
            end
            SEQ_DIV_T: if (div_rsp.done) total_ff <= quo_up;
            SEQ_DIV_N: if (div_rsp.done) nblk_ff  <= quo_up;
            SEQ_DIV_B: begin
               if (div_rsp.done) begin
                  small_ff  <= div_rsp.quotient[BMAX_W-1:0];
                  large_ff  <= quo_up[BMAX_W-1:0];
                  nlarge_ff <= div_rsp.remainder;
               end
            end
            default: ;
         endcase
      end
   end

   // Stage load enables: load when empty or when the successor moves
   assign ld4 = !s4_valid_ff || rsp.ready;
   assign ld3 = !s3_valid_ff || ld4;
   assign ld2 = !s2_valid_ff || ld3;
   assign ld1 = !s1_valid_ff || ld2;
   assign req.ready = ld1 && !part_busy && !csr_we;

   // Stage 1: pick the block length and scale the block number
   always_comb begin
      s1_blk_ok_in = (LEN_W'(req.block_number) < nblk_ff);
      s1_large_in  = (LEN_W'(req.block_number) < nlarge_ff);
      s1_bsyms_in  = '0;
      if (s1_blk_ok_in) begin
         s1_bsyms_in = s1_large_in ? large_ff : small_ff;
      end
      s1_prod_in = LEN_W'(req.block_number) * LEN_W'(small_ff);
      s1_min_in  = s1_large_in ? req.block_number : nlarge_ff[SBN_W-1:0];
   end

   // Stage 2: symbol number within the object
   assign s2_ok_in  = s1_blk_ok_ff && (BMAX_W'(s1_esi_ff) < s1_bsyms_ff);
   assign s2_sym_in = s1_prod_ff + LEN_W'(s1_min_ff) + LEN_W'(s1_esi_ff);

   // Stage 3: byte offset
   assign s3_offset_in = LEN_W'(s2_sym_ff * esz_ff);

   // Stage 4: shorten the last symbol to the bytes left
   assign s4_rest    = len_ff - s3_offset_ff;
   assign s4_slen_in = !s3_ok_ff ? '0 :
                       (s4_rest < LEN_W'(esz_ff)) ? s4_rest[ESZ_W-1:0] : esz_ff;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (ld1) s1_valid_ff <= req.valid && req.ready;
         if (ld2) s2_valid_ff <= s1_valid_ff;
         if (ld3) s3_valid_ff <= s2_valid_ff;
         if (ld4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_blk_ok_ff <= s1_blk_ok_in;
         s1_bsyms_ff  <= s1_bsyms_in;
         s1_prod_ff   <= s1_prod_in;
         s1_min_ff    <= s1_min_in;
         s1_esi_ff    <= req.symbol_index;
      end
      if (ld2) begin
         s2_ok_ff    <= s2_ok_in;
         s2_bsyms_ff <= s1_bsyms_ff;
         s2_sym_ff   <= s2_sym_in;
      end
      if (ld3) begin
         s3_ok_ff     <= s2_ok_ff;
         s3_bsyms_ff  <= s2_bsyms_ff;
         s3_offset_ff <= s2_ok_ff ? s3_offset_in : '0;
      end
      if (ld4) begin
         s4_ok_ff     <= s3_ok_ff;
         s4_bsyms_ff  <= s3_bsyms_ff;
         s4_offset_ff <= s3_offset_ff;
         s4_slen_ff   <= s4_slen_in;
      end
   end

   // Drive the response
   assign rsp.valid         = s4_valid_ff;
   assign rsp.in_range      = s4_ok_ff;
   assign rsp.block_symbols = s4_bsyms_ff;
   assign rsp.sym_len       = s4_slen_ff;
   assign rsp.byte_offset   = s4_offset_ff;
   assign rsp.block_count   = nblk_ff;

   // No request is taken while the partition is being recomputed
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      part_busy |-> !req.ready)
      else $error("request accepted during partition recompute");

   // A register write always starts a recompute
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (seq_state_ff == SEQ_START))
      else $error("register write did not restart the partition");

   // Large blocks hold one symbol more than small ones exactly when some exist
   a_large_small: assert property (@(posedge clock) disable iff (reset)
      !part_busy |-> (large_ff == small_ff + BMAX_W'(nlarge_ff != '0)))
      else $error("large and small block lengths disagree");

   // An out-of-range response carries no length and no offset
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.in_range) |-> (rsp.sym_len == '0 && rsp.byte_offset == '0))
      else $error("out-of-range response carries a location");

   // An in-range symbol has bytes and lies in a non-empty block
   a_in_range_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.in_range) |-> (rsp.sym_len != '0 && rsp.block_symbols != '0))
      else $error("in-range response with empty symbol or block");

endmodule

// ===== tb/sbsl_location_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Source block symbol locator checker
// Watches the register port and both channels. Keeps its own copy of the
// partition registers, works out the location of every accepted lookup
// and compares each response transaction field by field, in order.
// ---------------------------------------------------------------------------
module sbsl_location_checker import sbsl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   sbsl_req_if                  req,
   sbsl_rsp_if                  rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   pending_lookups,
   output int                   fail_count
);

   typedef struct packed {
      logic              in_range;
      logic [BMAX_W-1:0] block_symbols;
      logic [ESZ_W-1:0]  sym_len;
      logic [LEN_W-1:0]  byte_offset;
      logic [LEN_W-1:0]  block_count;
   } symbol_location_type;

   logic [LEN_W-1:0]     object_bytes;
   logic [ESZ_W-1:0]     symbol_bytes;
   logic [BMAX_W-1:0]    block_limit;
   symbol_location_type  expected_locations[$];
   int                   mismatches = 0;

   // Partition the object and place one (block, symbol) pair in it
   function automatic symbol_location_type locate_symbol(input logic [SBN_W-1:0] sbn,
                                                         input logic [ESI_W-1:0] esi);
      longint unsigned len, esz, bmax, total, nblk, big, little, nbig;
      longint unsigned count, first, offset, rest;
      symbol_location_type loc;
      loc    = '0;
      len    = object_bytes;
      esz    = symbol_bytes;
      bmax   = block_limit;
      nblk   = 0;
      big    = 0;
      little = 0;
      nbig   = 0;
      // an empty object, a zero symbol size or a zero block limit has no blocks
      if (len != 0 && esz != 0 && bmax != 0) begin
         total  = (len + esz - 1) / esz;
         nblk   = (total + bmax - 1) / bmax;
         big    = (total + nblk - 1) / nblk;
         little = total / nblk;
         nbig   = total - little * nblk;
      end
      loc.block_count = LEN_W'(nblk);
      if (sbn < nblk) begin
         // large blocks come first, then the small ones
         if (sbn < nbig) begin
            count = big;
            first = sbn * big;
         end else begin
            count = little;
            first = nbig * big + (sbn - nbig) * little;
         end
         loc.block_symbols = BMAX_W'(count);
         if (esi < count) begin
            offset          = (first + esi) * esz;
            rest            = len - offset;
            loc.in_range    = 1'b1;
            loc.byte_offset = LEN_W'(offset);
            // shorten the last symbol of the object to what remains
            loc.sym_len     = (rest < esz) ? ESZ_W'(rest) : ESZ_W'(esz);
         end
      end
      return loc;
   endfunction

   task automatic flag_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch_channels
      symbol_location_type want;
      if (reset) begin
         object_bytes = TRANSFER_BYTES_RST;
         symbol_bytes = SYMBOL_BYTES_RST;
         block_limit  = MAX_BLOCK_SYMBOLS_RST;
         expected_locations.delete();
      end else begin
         // compare a response transaction with the oldest lookup
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (expected_locations.size() == 0) begin
               $error("location response with no lookup outstanding");
               mismatches++;
            end else begin
               want = expected_locations.pop_front();
               if (rsp.in_range !== want.in_range)
                  flag_field("in_range", 64'(want.in_range), 64'(rsp.in_range));
               if (rsp.block_symbols !== want.block_symbols)
                  flag_field("block_symbols", 64'(want.block_symbols), 64'(rsp.block_symbols));
               if (rsp.sym_len !== want.sym_len)
                  flag_field("sym_len", 64'(want.sym_len), 64'(rsp.sym_len));
               if (rsp.byte_offset !== want.byte_offset)
                  flag_field("byte_offset", 64'(want.byte_offset), 64'(rsp.byte_offset));
               if (rsp.block_count !== want.block_count)
                  flag_field("block_count", 64'(want.block_count), 64'(rsp.block_count));
            end
         end
         // predict every accepted lookup
         if (req.valid === 1'b1 && req.ready === 1'b1)
            expected_locations.push_back(locate_symbol(req.block_number, req.symbol_index));
         // track register writes
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_TRANSFER_BYTES:    object_bytes = csr_wdata[LEN_W-1:0];
               CSR_SYMBOL_BYTES:      symbol_bytes = csr_wdata[ESZ_W-1:0];
               CSR_MAX_BLOCK_SYMBOLS: block_limit  = csr_wdata[BMAX_W-1:0];
               default: ;
            endcase
         end
      end
      pending_lookups <= expected_locations.size();
      fail_count      <= mismatches;
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Source block symbol locator testbench
// Drives directed and random lookups through a series of partition
// settings, with random idling on both channels and one long response
// hold-off; the checker predicts and compares every response.
// ---------------------------------------------------------------------------
module tb_top import sbsl_pkg::*; ;

   localparam logic [LEN_W-1:0] MAX_OBJECT = {LEN_W{1'b1}};
   localparam int PHASE_LOOKUPS = 78;
   localparam int SQUEEZE_AFTER = 460;
   localparam int SQUEEZE_CYCLES = 200;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic                 calm;
   int                   lookups_sent;
   int                   pending_lookups;
   int                   fail_count;

   sbsl_req_if req_if ();
   sbsl_rsp_if rsp_if ();

   source_block_symbol_locator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sbsl_location_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req_if),
      .rsp             (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_lookups (pending_lookups),
      .fail_count      (fail_count)
   );

   always #5 clock = ~clock;

   // Give up on a hung run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Write one register, then hold until the partition is recomputed
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // Drain outstanding lookups, then load a new partition
   task automatic set_partition(input logic [LEN_W-1:0] len, input logic [ESZ_W-1:0] esz,
                                input logic [BMAX_W-1:0] bmax);
      // let the count take in a lookup accepted at this very edge
      @(posedge clock);
      while (pending_lookups != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      write_register(CSR_TRANSFER_BYTES, CSR_W'(len));
      write_register(CSR_SYMBOL_BYTES, CSR_W'(esz));
      write_register(CSR_MAX_BLOCK_SYMBOLS, CSR_W'(bmax));
   endtask

   // Offer one lookup until accepted; maybe idle afterwards
   task automatic send_lookup(input logic [SBN_W-1:0] sbn, input logic [ESI_W-1:0] esi,
                              input int gap_odds);
      req_if.valid        <= 1'b1;
      req_if.block_number <= sbn;
      req_if.symbol_index <= esi;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      lookups_sent++;
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Block count and large block length, used only to aim the lookups
   function automatic void partition_span(input longint unsigned len, input longint unsigned esz,
                                          input longint unsigned bmax,
                                          output longint unsigned n_blocks,
                                          output longint unsigned big_block);
      longint unsigned t;
      n_blocks  = 0;
      big_block = 0;
      if (len != 0 && esz != 0 && bmax != 0) begin
         t         = (len + esz - 1) / esz;
         n_blocks  = (t + bmax - 1) / bmax;
         big_block = (t + n_blocks - 1) / n_blocks;
      end
   endfunction

   // Load a partition and send lookups mostly aimed near its real blocks
   task automatic lookup_phase(input logic [LEN_W-1:0] len, input logic [ESZ_W-1:0] esz,
                               input logic [BMAX_W-1:0] bmax);
      longint unsigned n_blocks, big_block;
      int unsigned     sbn_hi, esi_hi;
      int              gap_odds;
      logic [SBN_W-1:0] sbn;
      logic [ESI_W-1:0] esi;
      set_partition(len, esz, bmax);
      partition_span(len, esz, bmax, n_blocks, big_block);
      sbn_hi   = (n_blocks >= 65535) ? 65535 : int'(n_blocks);
      esi_hi   = (big_block >= 65535) ? 65535 : int'(big_block);
      gap_odds = $urandom_range(0, 6);
      repeat (PHASE_LOOKUPS) begin
         if ($urandom_range(0, 3) != 0) begin
            sbn = SBN_W'($urandom_range(0, sbn_hi));
            esi = ($urandom_range(0, 3) == 0) ? ESI_W'(esi_hi - $urandom_range(0, 1))
                                               : ESI_W'($urandom_range(0, esi_hi));
         end else begin
            sbn = SBN_W'($urandom);
            esi = ESI_W'($urandom);
         end
         send_lookup(sbn, esi, gap_odds);
      end
      req_if.valid <= 1'b0;
   endtask

   // Response side: random stalls, one long hold-off, none at the end
   initial begin : drive_rsp_ready
      bit squeeze_done;
      squeeze_done = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (!squeeze_done && lookups_sent >= SQUEEZE_AFTER) begin
            rsp_if.ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            squeeze_done = 1'b1;
         end else if (calm) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 4) != 0) begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin : drive_lookups
      logic [LEN_W-1:0]  len;
      logic [ESZ_W-1:0]  esz;
      logic [BMAX_W-1:0] bmax;
      calm                = 1'b0;
      lookups_sent        = 0;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_TRANSFER_BYTES;
      csr_wdata           <= '0;
      req_if.valid        <= 1'b0;
      req_if.block_number <= '0;
      req_if.symbol_index <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty object after reset: everything out of range
      send_lookup(16'd0, 16'd0, 3);
      send_lookup(16'hFFFF, 16'hFFFF, 3);
      send_lookup(16'd1, 16'd0, 3);
      req_if.valid <= 1'b0;

      // ten symbols in one large and two small blocks, short tail symbol
      set_partition(48'd10000, 16'd1024, 32'd4);
      send_lookup(16'd0, 16'd0, 3);
      send_lookup(16'd0, 16'd3, 3);
      send_lookup(16'd0, 16'd4, 3);
      send_lookup(16'd1, 16'd0, 3);
      send_lookup(16'd1, 16'd2, 3);
      send_lookup(16'd1, 16'd3, 3);
      send_lookup(16'd2, 16'd1, 3);
      send_lookup(16'd2, 16'd2, 3);
      send_lookup(16'd3, 16'd0, 3);
      send_lookup(16'd0, 16'hFFFF, 3);
      send_lookup(16'hFFFF, 16'd0, 3);
      send_lookup(16'hFFFF, 16'hFFFF, 3);
      req_if.valid <= 1'b0;

      // exact multiple of the symbol size: full length last symbol
      set_partition(48'd8192, 16'd1024, 32'd3);
      send_lookup(16'd1, 16'd2, 3);
      send_lookup(16'd2, 16'd1, 3);
      send_lookup(16'd2, 16'd2, 3);
      req_if.valid <= 1'b0;

      // extreme partitions, then zero symbol size and zero block limit
      lookup_phase(MAX_OBJECT, 16'd1, 32'd1);
      lookup_phase(MAX_OBJECT, 16'hFFFF, 32'hFFFF_FFFF);
      lookup_phase(48'd1, 16'hFFFF, 32'd64);
      lookup_phase(LEN_W'({$urandom, $urandom}), 16'd0, 32'($urandom));
      lookup_phase(48'd5000, 16'd100, 32'd0);

      // random partitions, the last one with no idling
      for (int p = 0; p < 7; p++) begin
         case ($urandom_range(0, 2))
            0:       len = LEN_W'($urandom_range(1, 5000));
            1:       len = LEN_W'($urandom_range(1, 1 << 24));
            default: len = LEN_W'({$urandom, $urandom});
         endcase
         esz  = ($urandom_range(0, 3) != 0) ? ESZ_W'($urandom_range(1, 2048))
                                            : ESZ_W'($urandom_range(1, 65535));
         bmax = ($urandom_range(0, 3) != 0) ? BMAX_W'($urandom_range(1, 50))
                                            : BMAX_W'($urandom);
         if (p == 6)
            calm = 1'b1;
         lookup_phase(len, esz, bmax);
      end

      // drain, then allow for any stray response
      @(posedge clock);
      while (pending_lookups != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sbsl_pkg.sv
rtl/sbsl_req_if.sv
rtl/sbsl_rsp_if.sv
rtl/sbsl_divider.sv
rtl/source_block_symbol_locator_unit.sv
tb/sbsl_location_checker.sv
tb/tb_top.sv
